FILE: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, command and register codes, and a timer helper.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_IDX_W  = 8;

  // Command codes carried by each tick.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WAIT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_WAIT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 8'd3;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef struct packed {
    timer_t     short_wait;
    timer_t     mid_wait;
    timer_t     long_wait;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;
  } result_t;

  // A hold of zero ticks behaves as one tick.
  function automatic timer_t hold_of(input timer_t v);
    hold_of = (v == '0) ? timer_t'(1) : v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/i2cm_cfg.sv
// ----------------------------------------------------------------------------
// I2C master configuration registers
// Holds the phase hold times and the ack timeout written over the cfg port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [15:0]                     wr_data,
  output i2cm_pkg::cfg_t                       cfg
);

  i2cm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_wait  <= i2cm_pkg::timer_t'(1);
      cfg_r.mid_wait    <= i2cm_pkg::timer_t'(2);
      cfg_r.long_wait   <= i2cm_pkg::timer_t'(4);
      cfg_r.ack_timeout <= 8'd250;
    end else if (wr_en) begin
      case (wr_index)
        i2cm_pkg::REG_SHORT_WAIT:  cfg_r.short_wait  <= wr_data;
        i2cm_pkg::REG_MID_WAIT:    cfg_r.mid_wait    <= wr_data;
        i2cm_pkg::REG_LONG_WAIT:   cfg_r.long_wait   <= wr_data;
        i2cm_pkg::REG_ACK_TIMEOUT: cfg_r.ack_timeout <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/i2cm_seq.sv
// ----------------------------------------------------------------------------
// I2C master phase sequencer
// Advances the bus phase by one tick per accepted item and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            tick,
  input  wire logic [2:0]      cmd,
  input  wire logic [7:0]      write_byte,
  input  wire logic            send_ack,
  input  wire logic            sda_sample,
  input  wire i2cm_pkg::cfg_t  cfg,
  output i2cm_pkg::result_t    res,
  output logic                 idle
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
    PH_WR_SET, PH_WR_HIGH, PH_WR_LOW, PH_WA_REL, PH_WA_HIGH, PH_WA_POLL,
    PH_RD_LOW, PH_RD_HIGH, PH_RA_LOW, PH_RA_HIGH
  } phase_t;

  phase_t            phase_r, phase_nxt, target;
  logic [2:0]        bit_cnt_r, bit_cnt_nxt;
  logic [7:0]        shift_r, shift_nxt;
  i2cm_pkg::timer_t  wait_r, wait_nxt;
  logic [7:0]        ack_wait_r, ack_wait_nxt;
  logic              scl_r, scl_nxt, sda_r, sda_nxt;
  logic              err_r, err_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic              ack_bit_r, ack_bit_nxt;
  logic              done, do_enter;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    wait_nxt     = wait_r;
    ack_wait_nxt = ack_wait_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    err_nxt      = err_r;
    hold_nxt     = hold_r;
    ack_bit_nxt  = ack_bit_r;
    done         = 1'b0;
    do_enter     = 1'b0;
    target       = PH_IDLE;

    if (phase_r == PH_IDLE) begin
      bit_cnt_nxt = '0;
      case (cmd)
        i2cm_pkg::CMD_START: begin
          target = PH_ST_A; do_enter = 1'b1;
        end
        i2cm_pkg::CMD_STOP: begin
          target = PH_SP_A; do_enter = 1'b1;
        end
        i2cm_pkg::CMD_WRITE: begin
          shift_nxt = write_byte; err_nxt = 1'b0;
          target = PH_WR_SET; do_enter = 1'b1;
        end
        i2cm_pkg::CMD_READ: begin
          shift_nxt = '0; ack_bit_nxt = send_ack;
          target = PH_RD_LOW; do_enter = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (phase_r != PH_WA_POLL && wait_r > i2cm_pkg::timer_t'(1)) begin
      wait_nxt = wait_r - i2cm_pkg::timer_t'(1);
    end else begin
      // The current phase has run out its hold: move on.
      case (phase_r)
        PH_ST_A:    begin target = PH_ST_B;    do_enter = 1'b1; end
        PH_ST_B:    begin scl_nxt = 1'b0; done = 1'b1; end
        PH_SP_A:    begin target = PH_SP_B;    do_enter = 1'b1; end
        PH_SP_B:    done = 1'b1;
        PH_WR_SET:  begin target = PH_WR_HIGH; do_enter = 1'b1; end
        PH_WR_HIGH: begin target = PH_WR_LOW;  do_enter = 1'b1; end
        PH_WR_LOW: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          do_enter  = 1'b1;
          if (bit_cnt_r != 3'd7) begin
            bit_cnt_nxt = bit_cnt_r + 3'd1; target = PH_WR_SET;
          end else begin
            bit_cnt_nxt = '0; target = PH_WA_REL;
          end
        end
        PH_WA_REL:  begin target = PH_WA_HIGH; do_enter = 1'b1; end
        PH_WA_HIGH: begin target = PH_WA_POLL; do_enter = 1'b1; end
        PH_WA_POLL: begin
          if (!sda_sample) begin
            scl_nxt = 1'b0; done = 1'b1;
          end else if (ack_wait_r >= cfg.ack_timeout) begin
            err_nxt = 1'b1; target = PH_SP_A; do_enter = 1'b1;
          end else begin
            ack_wait_nxt = ack_wait_r + 8'd1;
          end
        end
        PH_RD_LOW:  begin target = PH_RD_HIGH; do_enter = 1'b1; end
        PH_RD_HIGH: begin
          shift_nxt = {shift_r[6:0], sda_sample};
          do_enter  = 1'b1;
          if (bit_cnt_r != 3'd7) begin
            bit_cnt_nxt = bit_cnt_r + 3'd1; target = PH_RD_LOW;
          end else begin
            bit_cnt_nxt = '0; hold_nxt = {shift_r[6:0], sda_sample};
            target = PH_RA_LOW;
          end
        end
        PH_RA_LOW:  begin target = PH_RA_HIGH; do_enter = 1'b1; end
        PH_RA_HIGH: begin scl_nxt = 1'b0; done = 1'b1; end
        default:    done = 1'b0;
      endcase
    end

    if (done) begin
      phase_nxt = PH_IDLE;
      wait_nxt  = '0;
    end

    // Entry actions of the phase being entered.
    if (do_enter) begin
      phase_nxt = target;
      case (target)
        PH_ST_A: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; wait_nxt = i2cm_pkg::hold_of(cfg.long_wait);
        end
        PH_ST_B: begin
          sda_nxt = 1'b0; wait_nxt = i2cm_pkg::hold_of(cfg.long_wait);
        end
        PH_SP_A: begin
          scl_nxt = 1'b0; sda_nxt = 1'b0; wait_nxt = i2cm_pkg::hold_of(cfg.long_wait);
        end
        PH_SP_B: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; wait_nxt = i2cm_pkg::hold_of(cfg.long_wait);
        end
        PH_WR_SET: begin
          scl_nxt = 1'b0; sda_nxt = shift_nxt[7];
          wait_nxt = i2cm_pkg::hold_of(cfg.mid_wait);
        end
        PH_WR_HIGH: begin
          scl_nxt = 1'b1; wait_nxt = i2cm_pkg::hold_of(cfg.mid_wait);
        end
        PH_WR_LOW: begin
          scl_nxt = 1'b0; wait_nxt = i2cm_pkg::hold_of(cfg.mid_wait);
        end
        PH_WA_REL: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; wait_nxt = i2cm_pkg::hold_of(cfg.mid_wait);
        end
        PH_WA_HIGH: begin
          scl_nxt = 1'b1; wait_nxt = i2cm_pkg::hold_of(cfg.short_wait);
        end
        PH_WA_POLL: begin
          ack_wait_nxt = '0; wait_nxt = '0;
        end
        PH_RD_LOW: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1; wait_nxt = i2cm_pkg::hold_of(cfg.mid_wait);
        end
        PH_RD_HIGH: begin
          scl_nxt = 1'b1; wait_nxt = i2cm_pkg::hold_of(cfg.short_wait);
        end
        PH_RA_LOW: begin
          scl_nxt = 1'b0; sda_nxt = !ack_bit_nxt;
          wait_nxt = i2cm_pkg::hold_of(cfg.mid_wait);
        end
        PH_RA_HIGH: begin
          scl_nxt = 1'b1; wait_nxt = i2cm_pkg::hold_of(cfg.mid_wait);
        end
        default: begin
          phase_nxt = PH_IDLE; wait_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      wait_r     <= '0;
      ack_wait_r <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      err_r      <= 1'b0;
      hold_r     <= '0;
      ack_bit_r  <= 1'b0;
    end else if (tick) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      wait_r     <= wait_nxt;
      ack_wait_r <= ack_wait_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      err_r      <= err_nxt;
      hold_r     <= hold_nxt;
      ack_bit_r  <= ack_bit_nxt;
    end
  end

  assign res.scl_level = scl_nxt;
  assign res.sda_level = sda_nxt;
  assign res.busy_res  = (phase_nxt != PH_IDLE);
  assign res.done_res  = done;
  assign res.read_byte = hold_nxt;
  assign res.ack_error = err_nxt;
  assign idle          = (phase_r == PH_IDLE);

endmodule

`default_nettype wire

FILE: sv/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven I2C master that sequences SCL and SDA for start, stop, write
// byte and read byte commands.
// ----------------------------------------------------------------------------
// Each accepted input item is one time-base tick: the phase sequencer
// updates its state in the cycle of the transfer and the line levels and
// status for that tick are loaded into the output register, so a new tick
// can be accepted every cycle while out_ready is high. A command is taken
// only on a tick that finds the engine idle; commands given while busy are
// ignored. Phase hold times come from the cfg registers, which should be
// written only while the engine is idle.
`default_nettype none

module i2c_master_bit_engine (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Tick channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      in_cmd,
  input  wire logic [7:0]                      in_write_byte,
  input  wire logic                            in_send_ack,
  input  wire logic                            in_sda_sample,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_scl_level,
  output logic                                 out_sda_level,
  output logic                                 out_busy_res,
  output logic                                 out_done_res,
  output logic [7:0]                           out_read_byte,
  output logic                                 out_ack_error,
  // Configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]                     cfg_data
);

  i2cm_pkg::cfg_t    cfg;
  i2cm_pkg::result_t res;
  i2cm_pkg::result_t res_r;
  logic              out_valid_r, out_valid_nxt;
  logic              in_fire;
  logic              seq_idle;

  assign cfg_ready = 1'b1;

  i2cm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  i2cm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (in_fire),
    .cmd        (in_cmd),
    .write_byte (in_write_byte),
    .send_ack   (in_send_ack),
    .sda_sample (in_sda_sample),
    .cfg        (cfg),
    .res        (res),
    .idle       (seq_idle)
  );

  assign out_valid_nxt = in_fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        res_r <= res;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = res_r.scl_level;
  assign out_sda_level = res_r.sda_level;
  assign out_busy_res  = res_r.busy_res;
  assign out_done_res  = res_r.done_res;
  assign out_read_byte = res_r.read_byte;
  assign out_ack_error = res_r.ack_error;

`ifndef SYNTHESIS
  // A command ends on a tick that already reports the engine idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while busy");

  // A write taken on an idle tick clears the error flag and goes busy.
  a_write_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && seq_idle && in_cmd == i2cm_pkg::CMD_WRITE
    |=> out_valid && out_busy_res && !out_ack_error && !out_scl_level)
    else $error("write command did not start cleanly");

  // An ack timeout always begins the stop sequence with both lines low.
  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ack_error) |-> out_busy_res && !out_scl_level && !out_sda_level)
    else $error("ack error without stop sequence");

  // A busy tick carries no new command, so the engine stays busy or ends.
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !seq_idle |=> out_busy_res || out_done_res)
    else $error("engine went idle without completing");
`endif

endmodule

`default_nettype wire
